FILE: rtl/core/bppd_pkg.sv
// Shared types and codes for the bitmap palette pixel decoder.
`timescale 1ns / 1ps

package bppd_pkg;

  // Pixel depth codes held in the format register.
  typedef enum logic [1:0] {
    FMT_1BPP  = 2'd0,
    FMT_4BPP  = 2'd1,
    FMT_8BPP  = 2'd2,
    FMT_24BPP = 2'd3
  } pix_fmt_t;

  // Byte position within a 24 bpp pixel.
  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } tc_phase_t;

  // Operation codes of an input word.
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Register reset values.
  localparam logic [12:0] WIDTH_RESET  = 13'd1;
  localparam logic [12:0] HEIGHT_RESET = 13'd1;

  // Input word: a palette write or one raw pixel-data byte.
  typedef struct packed {
    logic        operation;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;
  } in_word_t;

  // Output word: one decoded pixel.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_byte;
    logic        last_of_image;
  } out_word_t;

  // Configuration handed from the register block to the datapath.
  typedef struct packed {
    pix_fmt_t    pixel_format;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

endpackage

FILE: rtl/core/bppd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bppd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read in one process; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bppd_cfg.sv
// Configuration registers of the decoder behind an APB-style port.
`timescale 1ns / 1ps

module bppd_cfg
  import bppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register write decode; writes beyond the register list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT: cfg_nxt.pixel_format = pix_fmt_t'(pwdata[1:0]);
        REG_WIDTH:  cfg_nxt.image_width  = pwdata[12:0];
        REG_HEIGHT: cfg_nxt.image_height = pwdata[12:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= FMT_8BPP;
      cfg_r.image_width  <= WIDTH_RESET;
      cfg_r.image_height <= HEIGHT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = {30'd0, cfg_r.pixel_format};
      REG_WIDTH:  prdata = {19'd0, cfg_r.image_width};
      REG_HEIGHT: prdata = {19'd0, cfg_r.image_height};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/bmp_palette_pixel_decoder.sv
// Top level: unpacks uncompressed bitmap pixel data into 24-bit colour pixels.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, in_data) carries one word per
// handshake: either a palette write or one raw pixel-data byte. The output
// channel (out_valid, out_stall, out_data) carries one pixel per word with
// its colour, column, bottom-up row and end-of-byte and end-of-image flags.
// The APB-style cfg_ port holds pixel format, width and height; write it
// only while the decoder is idle.
// A taken byte is held in the unpacking stage, which issues its pixels into
// the output register. Throughput: one pixel a cycle while out_stall is low,
// set by the single palette read port; a 4 bpp byte issues up to two pixels
// and a 1 bpp byte up to eight, and a palette write or padding byte none.
// in_stall is raised while a byte still has pixels left to issue.
// When out_stall is high the pending pixel and the palette read data hold,
// and the unpacking stage waits to issue a pixel until the output register frees up.
// Synchronous reset clears all counters and the pipeline valids and loads
// the register defaults (8 bpp, 1 x 1 image); palette contents are kept
// and are undefined until written.

module bmp_palette_pixel_decoder
  import bppd_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = (MAX_WIDTH > 8192) ? 13 : $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 8192) ? 13 : $clog2(MAX_HEIGHT);
  localparam int PAW = $clog2(PALETTE_DEPTH);

  cfg_t cfg;

  // Configuration registers.
  bppd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Effective image size: zero acts as one, oversize saturates.
  logic [13:0] w_eff;
  logic [13:0] h_eff;

  always_comb begin
    priority if (cfg.image_width == 13'd0) begin
      w_eff = 14'd1;
    end else if (int'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, cfg.image_width};
    end
  end

  always_comb begin
    priority if (cfg.image_height == 13'd0) begin
      h_eff = 14'd1;
    end else if (int'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = 14'(MAX_HEIGHT);
    end else begin
      h_eff = {1'b0, cfg.image_height};
    end
  end

  // Registers of the unpacking stage and the output stage.
  logic            b_valid_r, b_valid_nxt;
  logic [7:0]      b_byte_r, b_byte_nxt;
  logic [2:0]      b_pos_r, b_pos_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [1:0]      rb_r, rb_nxt;
  logic [1:0]      pad_r, pad_nxt;
  tc_phase_t       phase_r, phase_nxt;
  logic [15:0]     partial_r, partial_nxt;

  logic            s2_valid_r, s2_valid_nxt;
  logic            s2_direct_r;
  logic [23:0]     s2_rgb_r;
  logic [11:0]     s2_col_r;
  logic [11:0]     s2_row_r;
  logic            s2_lob_r;
  logic            s2_loi_r;

  // Handshake and step control.
  logic            in_accept;
  logic            s2_free;
  logic            pad_active;
  logic            emits;
  logic            last_pos;
  logic            byte_last;
  logic            go;
  logic            pix_go;
  logic            done;

  // Pixel of the current step.
  logic [7:0]      pal_idx;
  logic [13:0]     col_inc;
  logic [13:0]     row_inc;
  logic            row_done;
  logic            img_done;
  logic [13:0]     row_flip;
  logic [1:0]      rb_inc;
  logic [23:0]     ram_rdata;
  logic            pal_we;

  assign s2_free    = !s2_valid_r || !out_stall;
  assign pad_active = (pad_r != 2'd0);
  assign emits      = !pad_active &&
                      ((cfg.pixel_format != FMT_24BPP) || (phase_r == PH_RED));

  assign col_inc  = 14'(col_r) + 14'd1;
  assign row_inc  = 14'(row_r) + 14'd1;
  assign row_done = (col_inc >= w_eff);
  assign img_done = (row_inc >= h_eff);
  assign row_flip = h_eff - 14'd1 - 14'(row_r);
  assign rb_inc   = rb_r + 2'd1;

  // Palette index and last-pixel position for the current depth.
  always_comb begin
    unique case (cfg.pixel_format)
      FMT_1BPP: begin
        pal_idx  = {7'd0, b_byte_r[~b_pos_r]};
        last_pos = (b_pos_r == 3'd7);
      end
      FMT_4BPP: begin
        pal_idx  = b_pos_r[0] ? {4'd0, b_byte_r[3:0]} : {4'd0, b_byte_r[7:4]};
        last_pos = b_pos_r[0];
      end
      default: begin
        pal_idx  = b_byte_r;
        last_pos = 1'b1;
      end
    endcase
  end

  assign byte_last = !emits || row_done || last_pos;
  assign go        = b_valid_r && (!emits || s2_free);
  assign pix_go    = go && emits;
  assign done      = go && byte_last;

  assign in_stall  = b_valid_r && !done;
  assign in_accept = in_valid && !in_stall;
  assign pal_we    = in_accept && (in_data.operation == OP_PALETTE);

  // Palette store.
  bppd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PAW'(in_data.palette_index)),
    .wdata (in_data.palette_color),
    .re    (pix_go),
    .raddr (PAW'(pal_idx)),
    .rdata (ram_rdata)
  );

  // Unpacking stage next state: byte slot, counters, padding, 24 bpp assembly.
  always_comb begin
    b_valid_nxt = b_valid_r;
    b_byte_nxt  = b_byte_r;
    b_pos_nxt   = b_pos_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    rb_nxt      = rb_r;
    pad_nxt     = pad_r;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;

    if (done) begin
      b_valid_nxt = 1'b0;
    end else if (pix_go) begin
      b_pos_nxt = b_pos_r + 3'd1;
    end
    if (in_accept && (in_data.operation == OP_PIXEL)) begin
      b_valid_nxt = 1'b1;
      b_byte_nxt  = in_data.data_byte;
      b_pos_nxt   = 3'd0;
    end

    // Swallowed padding byte.
    if (go && pad_active) begin
      pad_nxt = pad_r - 2'd1;
    end

    // Truecolour byte assembly.
    if (go && !pad_active && (cfg.pixel_format == FMT_24BPP)) begin
      unique case (phase_r)
        PH_BLUE: begin
          partial_nxt = {8'd0, b_byte_r};
          phase_nxt   = PH_GREEN;
        end
        PH_GREEN: begin
          partial_nxt = {b_byte_r, partial_r[7:0]};
          phase_nxt   = PH_RED;
        end
        default: begin
          phase_nxt = PH_BLUE;
        end
      endcase
    end

    // Column and row counters advance once per pixel.
    if (pix_go) begin
      if (row_done) begin
        col_nxt = '0;
        row_nxt = img_done ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end

    // Row byte count and padding arm at the end of each non-padding byte.
    if (done && !pad_active) begin
      if (pix_go && row_done) begin
        pad_nxt = 2'd0 - rb_inc;
        rb_nxt  = 2'd0;
      end else begin
        rb_nxt = rb_inc;
      end
    end
  end

  assign s2_valid_nxt = s2_free ? pix_go : s2_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      b_pos_r    <= 3'd0;
      col_r      <= '0;
      row_r      <= '0;
      rb_r       <= 2'd0;
      pad_r      <= 2'd0;
      phase_r    <= PH_BLUE;
      partial_r  <= 16'd0;
      s2_valid_r <= 1'b0;
    end else begin
      b_valid_r  <= b_valid_nxt;
      b_pos_r    <= b_pos_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      rb_r       <= rb_nxt;
      pad_r      <= pad_nxt;
      phase_r    <= phase_nxt;
      partial_r  <= partial_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers of the unpacking and output stages.
  always_ff @(posedge clk) begin
    b_byte_r <= b_byte_nxt;
    if (pix_go) begin
      s2_direct_r <= (cfg.pixel_format == FMT_24BPP);
      s2_rgb_r    <= {b_byte_r, partial_r[15:8], partial_r[7:0]};
      s2_col_r    <= 12'(col_r);
      s2_row_r    <= row_flip[11:0];
      s2_lob_r    <= byte_last;
      s2_loi_r    <= row_done && img_done;
    end
  end

  // Output word: truecolour pixels bypass the palette read data.
  assign out_valid              = s2_valid_r;
  assign out_data.red           = s2_direct_r ? s2_rgb_r[23:16] : ram_rdata[23:16];
  assign out_data.green         = s2_direct_r ? s2_rgb_r[15:8]  : ram_rdata[15:8];
  assign out_data.blue          = s2_direct_r ? s2_rgb_r[7:0]   : ram_rdata[7:0];
  assign out_data.column        = s2_col_r;
  assign out_data.row           = s2_row_r;
  assign out_data.last_of_byte  = s2_lob_r;
  assign out_data.last_of_image = s2_loi_r;

  // The image's final pixel always ends its byte.
  a_loi_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_of_image |-> out_data.last_of_byte)
    else $error("last_of_image without last_of_byte");

  // Padding is only armed at a row boundary, so the row byte count is then zero.
  a_pad_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r != 2'd0 |-> rb_r == 2'd0)
    else $error("padding pending with a nonzero row byte count");

  // A 4 bpp byte never goes beyond its second nibble.
  a_nibble_pos: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && (cfg.pixel_format == FMT_4BPP) |-> b_pos_r <= 3'd1)
    else $error("4 bpp position past the low nibble");

  // A pixel issued while the output is free shows up in the next cycle.
  a_pixel_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pix_go |=> out_valid)
    else $error("issued pixel missing from the output register");

  // The unpacking slot refills only through an accepted pixel byte.
  a_slot_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !b_valid_r && !(in_valid && !in_stall && in_data.operation == OP_PIXEL)
      |=> !b_valid_r)
    else $error("unpacking slot filled without an accepted byte");

endmodule

FILE: bench/tb_bmp_palette_pixel_decoder.sv
// Self-checking testbench for the bitmap palette pixel decoder.
`timescale 1ns / 1ps

module tb_bmp_palette_pixel_decoder
  import bppd_pkg::*;
();

  localparam int LONG_HOLD   = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_SIZE    = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Words waiting to be offered and pixels waiting to be seen.
  in_word_t  words_to_send [$];
  out_word_t pending_pixels [$];
  int        words_queued = 0;
  int        words_taken = 0;
  int        mismatches = 0;
  int        src_idle_pct = 6;
  int        rx_idle_pct = 53;
  int        holds_asked = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  // Palette entries the stimulus has already written.
  bit        pal_written [256];

  // Register copies as last written on the configuration port.
  pix_fmt_t    cfg_format = FMT_8BPP;
  logic [12:0] cfg_width = WIDTH_RESET;
  logic [12:0] cfg_height = HEIGHT_RESET;

  // Decoder state as predicted by the bench.
  logic [23:0] palette_mem [256];
  logic [11:0] col_cnt;
  logic [11:0] row_cnt;
  logic [1:0]  byte_in_row;
  logic [1:0]  pad_left;
  tc_phase_t   tc_phase;
  logic [15:0] tc_partial;

  bmp_palette_pixel_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // A size register of zero behaves as one; anything above the maximum saturates.
  function automatic int clamp_size(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (int'(v) > MAX_SIZE) return MAX_SIZE;
    return int'(v);
  endfunction

  // Builds one pixel at the current position and moves the position on.
  function automatic out_word_t place_pixel(input logic [23:0] rgb, output bit row_end);
    out_word_t px;
    int        w;
    int        h;
    w = clamp_size(cfg_width);
    h = clamp_size(cfg_height);
    px = '0;
    px.red = rgb[23:16];
    px.green = rgb[15:8];
    px.blue = rgb[7:0];
    px.column = col_cnt;
    px.row = 12'(h - 1 - int'(row_cnt));
    row_end = 1'b0;
    if (int'(col_cnt) + 1 >= w) begin
      col_cnt = '0;
      row_end = 1'b1;
      if (int'(row_cnt) + 1 >= h) begin
        row_cnt = '0;
        px.last_of_image = 1'b1;
      end else begin
        row_cnt = row_cnt + 12'd1;
      end
    end else begin
      col_cnt = col_cnt + 12'd1;
    end
    return px;
  endfunction

  // Works out the pixels that one accepted word produces and queues them.
  task automatic decode_word(input in_word_t w);
    out_word_t  batch [8];
    int         k;
    int         i;
    bit         row_done;
    logic [7:0] b;
    k = 0;
    row_done = 1'b0;
    b = w.data_byte;
    if (w.operation == OP_PALETTE) begin
      palette_mem[w.palette_index] = w.palette_color;
    end else if (pad_left != 2'd0) begin
      // Row padding is swallowed whatever its value.
      pad_left = pad_left - 2'd1;
    end else begin
      unique case (cfg_format)
        FMT_1BPP: begin
          for (i = 7; i >= 0 && !row_done; i--) begin
            batch[k] = place_pixel(palette_mem[b[i]], row_done);
            k++;
          end
        end
        FMT_4BPP: begin
          batch[0] = place_pixel(palette_mem[b[7:4]], row_done);
          k = 1;
          if (!row_done) begin
            batch[1] = place_pixel(palette_mem[b[3:0]], row_done);
            k = 2;
          end
        end
        FMT_8BPP: begin
          batch[0] = place_pixel(palette_mem[b], row_done);
          k = 1;
        end
        default: begin
          // True colour collects blue, then green, then emits on red.
          unique case (tc_phase)
            PH_BLUE: begin
              tc_partial = {8'h00, b};
              tc_phase = PH_GREEN;
            end
            PH_GREEN: begin
              tc_partial[15:8] = b;
              tc_phase = PH_RED;
            end
            default: begin
              batch[0] = place_pixel({b, tc_partial[15:8], tc_partial[7:0]}, row_done);
              k = 1;
              tc_phase = PH_BLUE;
            end
          endcase
        end
      endcase
      byte_in_row = byte_in_row + 2'd1;
      if (row_done) begin
        pad_left = 2'd0 - byte_in_row;
        byte_in_row = 2'd0;
      end
      if (k > 0) begin
        batch[k - 1].last_of_byte = 1'b1;
      end
      for (i = 0; i < k; i++) begin
        pending_pixels.push_back(batch[i]);
      end
    end
  endtask

  // Reset drive: held low from the start, released once.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Input driver: offers queued words, predicting each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      col_cnt = '0;
      row_cnt = '0;
      byte_in_row = '0;
      pad_left = '0;
      tc_phase = PH_BLUE;
      tc_partial = '0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_word(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= words_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One line per mismatch, counted for the final verdict.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Compares a received pixel with the oldest expected one.
  task automatic check_pixel(input out_word_t got);
    out_word_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel at column %0d row %0d",
                                got.column, got.row));
    end else begin
      want = pending_pixels.pop_front();
      if (got.red !== want.red)
        report_mismatch($sformatf("red %0h, expected %0h", got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("green %0h, expected %0h", got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue %0h, expected %0h", got.blue, want.blue));
      if (got.column !== want.column)
        report_mismatch($sformatf("column %0d, expected %0d", got.column, want.column));
      if (got.row !== want.row)
        report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.last_of_byte !== want.last_of_byte)
        report_mismatch($sformatf("last_of_byte %0b, expected %0b",
                                  got.last_of_byte, want.last_of_byte));
      if (got.last_of_image !== want.last_of_image)
        report_mismatch($sformatf("last_of_image %0b, expected %0b",
                                  got.last_of_image, want.last_of_image));
    end
  endtask

  // Output monitor: checks taken pixels and drives the stall, long holds included.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_pixel(out_data);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_bmp_palette_pixel_decoder: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input in_word_t w);
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic queue_palette(input logic [7:0] idx, input logic [23:0] colour);
    in_word_t w;
    w.operation = OP_PALETTE;
    w.palette_index = idx;
    w.palette_color = colour;
    w.data_byte = 8'($urandom_range(255));
    pal_written[idx] = 1'b1;
    queue_word(w);
  endtask

  // Writes a palette entry first if it has never been written.
  task automatic make_ready(input logic [7:0] idx);
    if (!pal_written[idx]) begin
      queue_palette(idx, 24'($urandom()));
    end
  endtask

  // Queues one pixel-data byte, preceded by any palette entries it may read.
  task automatic queue_byte(input logic [7:0] b);
    in_word_t w;
    unique case (cfg_format)
      FMT_1BPP: begin
        make_ready(8'd0);
        make_ready(8'd1);
      end
      FMT_4BPP: begin
        make_ready({4'd0, b[7:4]});
        make_ready({4'd0, b[3:0]});
      end
      FMT_8BPP: make_ready(b);
      default: ;
    endcase
    w.operation = OP_PIXEL;
    w.palette_index = 8'($urandom_range(255));
    w.palette_color = 24'($urandom());
    w.data_byte = b;
    queue_word(w);
  endtask

  // Waits until every queued word is taken and every pixel seen, then a margin.
  task automatic wait_drained(input int extra);
    while (words_taken != words_queued || pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (extra) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle completing on pready.
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    unique case (idx)
      REG_FORMAT: cfg_format = pix_fmt_t'(value[1:0]);
      REG_WIDTH:  cfg_width = value[12:0];
      default:    cfg_height = value[12:0];
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic configure(input pix_fmt_t fmt, input int width, input int height);
    wait_drained(4);
    program_reg(REG_FORMAT, {30'd0, fmt});
    program_reg(REG_WIDTH, 32'(width));
    program_reg(REG_HEIGHT, 32'(height));
  endtask

  // Mostly small sizes, sometimes zero, the maximum or beyond it.
  function automatic int pick_size(input int small_max);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return MAX_SIZE;
    if (r < 22) return 8191;
    if (r < 26) return MAX_SIZE - 1;
    return $urandom_range(small_max, 1);
  endfunction

  // Stimulus: directed cases, then random phases under three idling regimes.
  initial begin
    int p;
    int n;
    pix_fmt_t fmt;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Default 8 bpp, 1 x 1: bytes one and five end the image and arm three pads.
    queue_palette(8'd0, 24'h000000);
    queue_palette(8'd255, 24'hFFFFFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);

    // 1 bpp, ten wide: three leftover pads go first, then the second byte of
    // the row is cut short and arms two pads.
    configure(FMT_1BPP, 10, 2);
    queue_byte(8'hA5);
    queue_byte(8'hC0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_byte(8'h3F);

    // 4 bpp, three wide: the leftover pad comes first, then the low nibble is dropped.
    configure(FMT_4BPP, 3, 1);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h12);
    queue_byte(8'h3F);

    // 24 bpp with zero width and an oversize height.
    configure(FMT_24BPP, 0, 8191);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);

    // Random phases; the state carries over between settings.
    for (p = 0; p < 9; p++) begin
      wait_drained(4);
      unique case (p / 3)
        0: begin
          src_idle_pct = 6;
          rx_idle_pct = 53;
        end
        1: begin
          src_idle_pct = 53;
          rx_idle_pct = 6;
        end
        default: begin
          src_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (p == 6) begin
        // Long output hold while 1 bpp bytes keep coming, so the decoder backs up.
        configure(FMT_1BPP, 24, 3);
        holds_asked++;
      end else begin
        fmt = pix_fmt_t'($urandom_range(3));
        configure(fmt, pick_size(24), pick_size(4));
      end
      for (n = 0; n < 7; n++) begin
        if ($urandom_range(99) < 20) begin
          queue_palette(8'($urandom_range(255)), 24'($urandom()));
        end else begin
          queue_byte(8'($urandom_range(255)));
        end
      end
    end

    wait_drained(8);
    if (mismatches == 0) begin
      $display("tb_bmp_palette_pixel_decoder: PASS");
    end else begin
      $display("tb_bmp_palette_pixel_decoder: FAIL");
    end
    $finish;
  end

endmodule
